// ----- hw/rtl/ppp_pkg.sv -----
`default_nettype none
package ppp_pkg;

  localparam int unsigned NumCoef  = 12;
  localparam int unsigned IdxWidth = 4;
  localparam int unsigned NumCols  = 4;

  typedef enum logic {
    OpLoad    = 1'b0,
    OpProject = 1'b1
  } opcode_e;

endpackage
`default_nettype wire

// ----- hw/rtl/perspective_point_projection_unit.sv -----
// Throughput: one item per cycle unless out_ready_i back-pressure stalls the pipeline;
//   each of the COORD_WIDTH divider stages retires one quotient bit of u/w and v/w,
//   after a product stage, a row-sum stage and a setup stage.
// Load beats write the matrix at acceptance and produce no result.
// Reset (rst_ni low, async) clears all stage valid bits and zeroes the camera matrix.
`default_nettype none
module perspective_point_projection_unit #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 opcode_i,
  input  wire logic [ppp_pkg::IdxWidth-1:0]         coef_index_i,
  input  wire logic signed [COORD_WIDTH-1:0]        coef_value_i,
  input  wire logic signed [COORD_WIDTH-1:0]        world_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]        world_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]        world_z_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [COORD_WIDTH-1:0]             image_x_o,
  output logic signed [COORD_WIDTH-1:0]             image_y_o,
  output logic                                      depth_fault_o,
  output logic                                      saturated_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned DW = SW + CW + FRAC_BITS;
  localparam logic [CW-1:0] MaxNeg = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] MaxPos = {1'b0, {(CW-1){1'b1}}};

  logic signed [CW-1:0] coef_q [ppp_pkg::NumCoef];

  // ready chain
  logic ro, r1, r2;
  logic rd [CW+1];
  logic in_acc;

  logic                 v1_q;
  logic signed [PW-1:0] p_q [ppp_pkg::NumCoef];
  logic                 v2_q;
  logic signed [SW-1:0] u_q, v_q, w_q;

  logic          dv_q   [CW+1];
  logic [DW-1:0] ru_q   [CW+1];
  logic [DW-1:0] rv_q   [CW+1];
  logic [CW-1:0] qu_q   [CW+1];
  logic [CW-1:0] qv_q   [CW+1];
  logic [SW-1:0] den_q  [CW+1];
  logic          negu_q [CW+1];
  logic          negv_q [CW+1];
  logic          ovfu_q [CW+1];
  logic          ovfv_q [CW+1];
  logic          flt_q  [CW+1];

  logic vo_q;

  assign ro         = ~vo_q | out_ready_i;
  assign rd[CW]     = ~dv_q[CW] | ro;
  for (genvar k = 0; k < CW; k++) begin : g_rdy
    assign rd[k] = ~dv_q[k] | rd[k+1];
  end
  assign r2         = ~v2_q | rd[0];
  assign r1         = ~v1_q | r2;
  assign in_ready_o = r1;
  assign in_acc     = in_valid_i & r1;

  // coefficient store, written at acceptance of a load beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppp_pkg::NumCoef; i++) coef_q[i] <= '0;
    end else if (in_acc && (ppp_pkg::opcode_e'(opcode_i) == ppp_pkg::OpLoad)
                 && (coef_index_i < ppp_pkg::IdxWidth'(ppp_pkg::NumCoef))) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // stage 1: products; column 3 multiplies by 1.0
  logic signed [PW-1:0] p_d [ppp_pkg::NumCoef];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p_d[r*ppp_pkg::NumCols]     = PW'(coef_q[r*ppp_pkg::NumCols])     * PW'(world_x_i);
      p_d[r*ppp_pkg::NumCols + 1] = PW'(coef_q[r*ppp_pkg::NumCols + 1]) * PW'(world_y_i);
      p_d[r*ppp_pkg::NumCols + 2] = PW'(coef_q[r*ppp_pkg::NumCols + 2]) * PW'(world_z_i);
      p_d[r*ppp_pkg::NumCols + 3] = PW'(coef_q[r*ppp_pkg::NumCols + 3]) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (r1) v1_q <= in_acc && (ppp_pkg::opcode_e'(opcode_i) == ppp_pkg::OpProject);
  end
  always_ff @(posedge clk_i) begin
    if (r1) begin
      for (int i = 0; i < ppp_pkg::NumCoef; i++) p_q[i] <= p_d[i];
    end
  end

  // stage 2: row sums
  logic signed [SW-1:0] sum_d [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SW'(p_q[r*4]) + SW'(p_q[r*4+1]) + SW'(p_q[r*4+2]) + SW'(p_q[r*4+3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (r2) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (r2) begin
      u_q <= sum_d[0];
      v_q <= sum_d[1];
      w_q <= sum_d[2];
    end
  end

  // divider setup: magnitudes scaled by 2^FRAC_BITS, overflow when quotient >= 2^CW
  logic [SW-1:0] magu, magv;
  logic [DW-1:0] nu, nv, dtop;
  always_comb begin
    magu = u_q[SW-1] ? SW'(-u_q) : SW'(u_q);
    magv = v_q[SW-1] ? SW'(-v_q) : SW'(v_q);
    nu   = DW'(magu) << FRAC_BITS;
    nv   = DW'(magv) << FRAC_BITS;
    dtop = DW'(w_q) << CW;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (rd[0]) dv_q[0] <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (rd[0]) begin
      ru_q[0]   <= nu;
      rv_q[0]   <= nv;
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
      den_q[0]  <= SW'(w_q);
      negu_q[0] <= u_q[SW-1];
      negv_q[0] <= v_q[SW-1];
      ovfu_q[0] <= nu >= dtop;
      ovfv_q[0] <= nv >= dtop;
      flt_q[0]  <= w_q[SW-1] || (w_q == '0);
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 1; k <= CW; k++) begin : g_div
    localparam int unsigned Sh = CW - k;
    logic [DW-1:0] trial;
    logic          geu, gev;
    assign trial = DW'(den_q[k-1]) << Sh;
    assign geu   = ru_q[k-1] >= trial;
    assign gev   = rv_q[k-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else if (rd[k]) dv_q[k] <= dv_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (rd[k]) begin
        ru_q[k]      <= geu ? ru_q[k-1] - trial : ru_q[k-1];
        rv_q[k]      <= gev ? rv_q[k-1] - trial : rv_q[k-1];
        qu_q[k]      <= qu_q[k-1] | (CW'(geu) << Sh);
        qv_q[k]      <= qv_q[k-1] | (CW'(gev) << Sh);
        den_q[k]     <= den_q[k-1];
        negu_q[k]    <= negu_q[k-1];
        negv_q[k]    <= negv_q[k-1];
        ovfu_q[k]    <= ovfu_q[k-1];
        ovfv_q[k]    <= ovfv_q[k-1];
        flt_q[k]     <= flt_q[k-1];
      end
    end
  end

  // output stage: clamp, sign, fault masking
  logic [CW-1:0] limu, limv, mu, mv;
  logic          satu, satv;
  always_comb begin
    limu = negu_q[CW] ? MaxNeg : MaxPos;
    limv = negv_q[CW] ? MaxNeg : MaxPos;
    satu = ovfu_q[CW] || (qu_q[CW] > limu);
    satv = ovfv_q[CW] || (qv_q[CW] > limv);
    mu   = satu ? limu : qu_q[CW];
    mv   = satv ? limv : qv_q[CW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (ro) vo_q <= dv_q[CW];
  end
  always_ff @(posedge clk_i) begin
    if (ro) begin
      if (flt_q[CW]) begin
        image_x_o     <= '0;
        image_y_o     <= '0;
        depth_fault_o <= 1'b1;
        saturated_o   <= 1'b0;
      end else begin
        image_x_o     <= negu_q[CW] ? -mu : mu;
        image_y_o     <= negv_q[CW] ? -mv : mv;
        depth_fault_o <= 1'b0;
        saturated_o   <= satu | satv;
      end
    end
  end

  assign out_valid_o = vo_q;

endmodule
`default_nettype wire
